// ===== hw/rtl/fesp_pkg.sv =====
// Shared types, constants and the sector map of the erase sector planner.
package fesp_pkg;

  localparam int unsigned MAP_SLOTS   = 32;
  localparam int unsigned SLOT_W      = $clog2(MAP_SLOTS);
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned BYTES_W     = 18;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTES_W-1:0] SZ_16K  = 18'h04000;
  localparam logic [BYTES_W-1:0] SZ_64K  = 18'h10000;
  localparam logic [BYTES_W-1:0] SZ_128K = 18'h20000;

  localparam logic [ADDR_W-1:0] BANK1_BASE = 32'h0800_0000;
  localparam logic [ADDR_W-1:0] BANK2_BASE = 32'h0810_0000;

  typedef enum logic [1:0] {
    STAT_ERASE = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ERROR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FR_IDLE = 2'd0,
    FR_FIND = 2'd1,
    FR_SPAN = 2'd2,
    FR_PUSH = 2'd3
  } front_state_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] last;
  } cmd_t;

  // Size of one map slot; slots past the two banks are empty.
  function automatic logic [BYTES_W-1:0] slot_bytes(input logic [SLOT_W-1:0] idx);
    logic [BYTES_W-1:0] sz;
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd12, 5'd13, 5'd14, 5'd15: sz = SZ_16K;
      5'd4, 5'd16: sz = SZ_64K;
      5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
      5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23: sz = SZ_128K;
      default: sz = '0;
    endcase
    return sz;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] idx);
    logic [ADDR_W-1:0] b;
    case (idx)
      5'd0:  b = BANK1_BASE + 32'h0_0000;
      5'd1:  b = BANK1_BASE + 32'h0_4000;
      5'd2:  b = BANK1_BASE + 32'h0_8000;
      5'd3:  b = BANK1_BASE + 32'h0_C000;
      5'd4:  b = BANK1_BASE + 32'h1_0000;
      5'd5:  b = BANK1_BASE + 32'h2_0000;
      5'd6:  b = BANK1_BASE + 32'h4_0000;
      5'd7:  b = BANK1_BASE + 32'h6_0000;
      5'd8:  b = BANK1_BASE + 32'h8_0000;
      5'd9:  b = BANK1_BASE + 32'hA_0000;
      5'd10: b = BANK1_BASE + 32'hC_0000;
      5'd11: b = BANK1_BASE + 32'hE_0000;
      5'd12: b = BANK2_BASE + 32'h0_0000;
      5'd13: b = BANK2_BASE + 32'h0_4000;
      5'd14: b = BANK2_BASE + 32'h0_8000;
      5'd15: b = BANK2_BASE + 32'h0_C000;
      5'd16: b = BANK2_BASE + 32'h1_0000;
      5'd17: b = BANK2_BASE + 32'h2_0000;
      5'd18: b = BANK2_BASE + 32'h4_0000;
      5'd19: b = BANK2_BASE + 32'h6_0000;
      5'd20: b = BANK2_BASE + 32'h8_0000;
      5'd21: b = BANK2_BASE + 32'hA_0000;
      5'd22: b = BANK2_BASE + 32'hC_0000;
      5'd23: b = BANK2_BASE + 32'hE_0000;
      default: b = '0;
    endcase
    return b;
  endfunction

  // One past the last byte of a slot, in 33 bits.
  function automatic logic [ADDR_W:0] slot_end(input logic [SLOT_W-1:0] idx);
    return {1'b0, slot_base(idx)} + {{(ADDR_W + 1 - BYTES_W){1'b0}}, slot_bytes(idx)};
  endfunction

endpackage

// ===== hw/rtl/fesp_front.sv =====
// Request front end: accepts a request and scans the map for its first and last sector.
module fesp_front import fesp_pkg::*; #(
  parameter int unsigned SECTOR_COUNT = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ADDR_W-1:0]   range_start,
  input  logic [ADDR_W-1:0]   range_length,
  output logic                push,
  output cmd_t                push_cmd,
  input  logic                full
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SECTOR_COUNT - 1);

  front_state_t      state, state_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [ADDR_W:0]   span_end, span_end_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [SLOT_W-1:0] first, first_next;
  cmd_t              cmd, cmd_next;
  logic [ADDR_W:0]   cur_end;
  logic              holds;
  cmd_t              err_cmd;

  assign cur_end  = slot_end(slot);
  assign holds    = (addr >= slot_base(slot)) && ({1'b0, addr} < cur_end);
  assign err_cmd  = '{status: STAT_ERROR, first: '0, last: '0};
  assign busy     = (state != FR_IDLE);
  assign push     = (state == FR_PUSH) && !full;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
    addr     <= addr_next;
    span_end <= span_end_next;
    slot     <= slot_next;
    first    <= first_next;
    cmd      <= cmd_next;
  end

  always_comb begin
    state_next    = state;
    addr_next     = addr;
    span_end_next = span_end;
    slot_next     = slot;
    first_next    = first;
    cmd_next      = cmd;
    case (state)
      FR_IDLE: begin
        if (start) begin
          addr_next     = range_start;
          span_end_next = {1'b0, range_start} + {1'b0, range_length};
          slot_next     = '0;
          if (range_length == '0) begin
            cmd_next   = '{status: STAT_EMPTY, first: '0, last: '0};
            state_next = FR_PUSH;
          end else begin
            state_next = FR_FIND;
          end
        end
      end
      FR_FIND: begin
        if (holds) begin
          first_next = slot;
          if (cur_end >= span_end) begin
            cmd_next   = '{status: STAT_ERASE, first: slot, last: slot};
            state_next = FR_PUSH;
          end else if (slot == LAST_SLOT) begin
            cmd_next   = err_cmd;
            state_next = FR_PUSH;
          end else begin
            slot_next  = slot + 1'b1;
            state_next = FR_SPAN;
          end
        end else if (slot == LAST_SLOT) begin
          cmd_next   = err_cmd;
          state_next = FR_PUSH;
        end else begin
          slot_next = slot + 1'b1;
        end
      end
      FR_SPAN: begin
        if (cur_end >= span_end) begin
          cmd_next   = '{status: STAT_ERASE, first: first, last: slot};
          state_next = FR_PUSH;
        end else if (slot == LAST_SLOT) begin
          cmd_next   = err_cmd;
          state_next = FR_PUSH;
        end else begin
          slot_next = slot + 1'b1;
        end
      end
      FR_PUSH: begin
        if (!full) begin
          state_next = FR_IDLE;
        end
      end
      default: begin
        state_next = FR_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fesp_queue.sv =====
// Short command queue between the front end and the command emitter.
module fesp_queue import fesp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/fesp_back.sv =====
// Command emitter: walks one queued command and drives one result per cycle.
module fesp_back import fesp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  cmd_t                pop_cmd,
  output logic                pop,
  output logic                strobe,
  output logic [SLOT_W-1:0]   sector_number,
  output logic [ADDR_W-1:0]   sector_start,
  output logic [BYTES_W-1:0]  sector_bytes,
  output logic [1:0]          status,
  output logic                last_of_run
);

  logic              active;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] last_idx;
  status_t           cur_status;
  logic              at_last;

  assign pop     = !active && !empty;
  assign at_last = (idx == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (active) begin
        active <= !at_last;
      end else if (pop) begin
        active <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx        <= pop_cmd.first;
      last_idx   <= pop_cmd.last;
      cur_status <= pop_cmd.status;
    end else if (active && !at_last) begin
      idx <= idx + 1'b1;
    end
    if (active) begin
      status      <= cur_status;
      last_of_run <= at_last;
      if (cur_status == STAT_ERASE) begin
        sector_number <= idx;
        sector_start  <= slot_base(idx);
        sector_bytes  <= slot_bytes(idx);
      end else begin
        sector_number <= '0;
        sector_start  <= '0;
        sector_bytes  <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/flash_erase_sector_planner.sv =====
// Top level of the flash erase sector planner.
// A request (range_start, range_length) is taken when start is high and busy is low.
// The front end scans the dual-bank map one sector per cycle, so busy stays high for the
// whole scan of a request, plus while the front end waits on a full command queue.
// Results then leave one per cycle on strobe:
// one erase command per covered sector (up to 24), or a single empty or error result,
// with last_of_run marking the final one. A two-entry command queue lets the next
// request be scanned while the previous one is still being emitted. The receiver
// cannot stall: each result is valid for exactly the one cycle strobe is high.
module flash_erase_sector_planner import fesp_pkg::*; #(
  parameter int unsigned SECTOR_COUNT = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ADDR_W-1:0]   range_start,
  input  logic [ADDR_W-1:0]   range_length,
  output logic                strobe,
  output logic [SLOT_W-1:0]   sector_number,
  output logic [ADDR_W-1:0]   sector_start,
  output logic [BYTES_W-1:0]  sector_bytes,
  output logic [1:0]          status,
  output logic                last_of_run
);

  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;

  fesp_front #(
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .range_start (range_start),
    .range_length(range_length),
    .push        (push),
    .push_cmd    (push_cmd),
    .full        (full)
  );

  fesp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (full),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .empty   (empty)
  );

  fesp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_cmd      (pop_cmd),
    .pop          (pop),
    .strobe       (strobe),
    .sector_number(sector_number),
    .sector_start (sector_start),
    .sector_bytes (sector_bytes),
    .status       (status),
    .last_of_run  (last_of_run)
  );

  // Empty and error results always close their request.
  a_status_closes: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != STAT_ERASE) |-> last_of_run)
    else $error("status result without last_of_run");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != STAT_ERASE) |-> (sector_number == '0) && (sector_bytes == '0))
    else $error("status result carries sector data");

  a_erase_sized: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == STAT_ERASE) |-> (sector_bytes != '0))
    else $error("erase command for an empty slot");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("front end did not take the request");

endmodule
